### rtl/dcer_pkg.sv
// Shared constants and types for the digital change event recorder.
// No dependencies; every other file in rtl/ refers to it by scoped name.
package dcer_pkg;

   localparam int LINE_COUNT  = 64;
   localparam int SEGMENT_MAX = 32768;

   localparam int CNT_W      = $clog2(SEGMENT_MAX + 1);
   localparam int SLOT_W     = 15;
   localparam int LINE_NUM_W = 6;
   localparam int WORD_W     = 64;
   localparam int TICK_W     = 62;
   localparam int OFFSET_W   = 63;
   localparam int TIME_W     = 64;
   localparam int CHAN_W     = 7;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 63;

   localparam logic [CSR_IDX_W-1:0] CSR_CHANNELS_IN_USE = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TRIGGER_OFFSET  = 8'd1;

   localparam logic [CHAN_W-1:0] CHANNELS_RESET = 7'd64;

   // Strobes from the top level to every lane.
   typedef struct packed {
      logic load;
      logic seg_start;
      logic seg_end;
   } lane_ctrl_type;

   // What a lane reports for the item just loaded.
   typedef struct packed {
      logic              fire;
      logic [SLOT_W-1:0] slot;
   } lane_out_type;

endpackage

### rtl/digital_change_event_recorder_core.sv
// Top level of the digital change event recorder: configuration registers,
// one dcer_lane per input line and the dcer_merge serializer. Uses dcer_pkg.
//
// Each accepted item is one sampled word with its tick stamp and segment
// marks. In the accept cycle every line lane decides at once whether its line
// produces an event (segment start, segment end or a level change, line in
// use, record not full) and updates its own event count. The merge stage then
// emits the events one per cycle, while rsp_ready does not hold them off, in
// ascending line order through an output register, flagging the final one with
// last_event. The next item is taken as soon as the last event of the previous
// one has moved into the output register, even while that event still waits on
// rsp_ready. There is no clearing pass after reset: counts and the previous word
// live in per-lane flip-flops cleared by reset. Configuration writes go through
// csr_we/csr_index/csr_wdata and take effect at once; issue them only while the
// block idles, as nothing holds them off.
module digital_change_event_recorder_core (
   input  logic                                  clock,
   input  logic                                  reset,
   // configuration write port
   input  logic                                  csr_we,
   input  logic [dcer_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [dcer_pkg::CSR_DATA_W-1:0]       csr_wdata,
   // sample channel
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [dcer_pkg::WORD_W-1:0]           req_sample_word,
   input  logic [dcer_pkg::TICK_W-1:0]           req_tick_stamp,
   input  logic                                  req_segment_start,
   input  logic                                  req_segment_end,
   // event channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [dcer_pkg::LINE_NUM_W-1:0]       rsp_line_number,
   output logic                                  rsp_line_level,
   output logic signed [dcer_pkg::TIME_W-1:0]    rsp_event_time,
   output logic [dcer_pkg::SLOT_W-1:0]           rsp_event_slot,
   output logic                                  rsp_last_event
);

   logic [dcer_pkg::CHAN_W-1:0]   channels_ff;
   logic [dcer_pkg::OFFSET_W-1:0] offset_ff;

   dcer_pkg::lane_ctrl_type       ctrl;
   dcer_pkg::lane_out_type        lane_out [dcer_pkg::LINE_COUNT];
   logic [dcer_pkg::LINE_COUNT-1:0] fire_vec;
   logic [dcer_pkg::LINE_COUNT-1:0][dcer_pkg::SLOT_W-1:0] slot_vec;
   logic [dcer_pkg::LINE_COUNT-1:0] level_vec;
   logic [dcer_pkg::TIME_W-1:0]   event_time;
   logic                          idle;

   // Hold the configuration; only the listed indexes take effect.
   always_ff @(posedge clock) begin
      if (reset) begin
         channels_ff <= dcer_pkg::CHANNELS_RESET;
         offset_ff   <= '0;
      end else if (csr_we) begin
         case (csr_index)
            dcer_pkg::CSR_CHANNELS_IN_USE: channels_ff <= csr_wdata[dcer_pkg::CHAN_W-1:0];
            dcer_pkg::CSR_TRIGGER_OFFSET:  offset_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_ready      = idle;
   assign ctrl.load      = req_valid && idle;
   assign ctrl.seg_start = req_segment_start;
   assign ctrl.seg_end   = req_segment_end;

   // Tick stamp plus sign-extended trigger offset; the sum always fits.
   assign event_time = {2'b00, req_tick_stamp} + {offset_ff[dcer_pkg::OFFSET_W-1], offset_ff};

   for (genvar i = 0; i < dcer_pkg::LINE_COUNT; i++) begin : g_lane
      logic in_use;
      // A channel count above the lane count covers every lane.
      assign in_use       = channels_ff > dcer_pkg::CHAN_W'(i);
      assign level_vec[i] = req_sample_word[i];

      dcer_lane u_lane (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .in_use   (in_use),
         .level    (req_sample_word[i]),
         .lane_out (lane_out[i])
      );

      assign fire_vec[i] = lane_out[i].fire;
      assign slot_vec[i] = lane_out[i].slot;
   end

   dcer_merge u_merge (
      .clock           (clock),
      .reset           (reset),
      .load            (ctrl.load),
      .fire_vec        (fire_vec),
      .slot_vec        (slot_vec),
      .time_in         (event_time),
      .idle            (idle),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_line_number (rsp_line_number),
      .rsp_line_level  (rsp_line_level),
      .rsp_event_time  (rsp_event_time),
      .rsp_event_slot  (rsp_event_slot),
      .rsp_last_event  (rsp_last_event),
      .level_vec       (level_vec)
   );

endmodule

### rtl/dcer_lane.sv
// One input line: previous level, segment event count and slot of the item.
// Depends on dcer_pkg.
module dcer_lane (
   input  logic                   clock,
   input  logic                   reset,
   input  dcer_pkg::lane_ctrl_type ctrl,
   input  logic                   in_use,
   input  logic                   level,
   output dcer_pkg::lane_out_type lane_out
);

   logic                       prev_ff;
   logic [dcer_pkg::CNT_W-1:0] count_ff, count_in;
   logic [dcer_pkg::SLOT_W-1:0] slot_ff;
   logic [dcer_pkg::CNT_W-1:0] base;
   logic                       fire;

   always_comb begin
      // Segment start clears the count before the word is examined.
      base = ctrl.seg_start ? '0 : count_ff;
      fire = in_use && (ctrl.seg_start || ctrl.seg_end || (level != prev_ff))
             && (base < dcer_pkg::CNT_W'(dcer_pkg::SEGMENT_MAX));
      count_in = fire ? base + dcer_pkg::CNT_W'(1) : base;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= 1'b0;
         count_ff <= '0;
      end else if (ctrl.load) begin
         prev_ff  <= level;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         slot_ff <= dcer_pkg::SLOT_W'(base);
      end
   end

   assign lane_out.fire = fire;
   assign lane_out.slot = slot_ff;

endmodule

### rtl/dcer_merge.sv
// Merge stage: holds the fire mask of the current item and emits its events
// lowest line first into the output register. Depends on dcer_pkg.
module dcer_merge (
   input  logic                                             clock,
   input  logic                                             reset,
   input  logic                                             load,
   input  logic [dcer_pkg::LINE_COUNT-1:0]                  fire_vec,
   input  logic [dcer_pkg::LINE_COUNT-1:0][dcer_pkg::SLOT_W-1:0] slot_vec,
   input  logic [dcer_pkg::TIME_W-1:0]                      time_in,
   output logic                                             idle,
   output logic                                             rsp_valid,
   input  logic                                             rsp_ready,
   output logic [dcer_pkg::LINE_NUM_W-1:0]                  rsp_line_number,
   output logic                                             rsp_line_level,
   output logic signed [dcer_pkg::TIME_W-1:0]               rsp_event_time,
   output logic [dcer_pkg::SLOT_W-1:0]                      rsp_event_slot,
   output logic                                             rsp_last_event,
   input  logic [dcer_pkg::LINE_COUNT-1:0]                  level_vec
);

   logic [dcer_pkg::LINE_COUNT-1:0]   mask_ff, mask_in;
   logic [dcer_pkg::LINE_COUNT-1:0]   levels_ff;
   logic [dcer_pkg::TIME_W-1:0]       time_ff;
   logic                              valid_ff, valid_in;
   logic [dcer_pkg::LINE_NUM_W-1:0]   line_ff;
   logic                              level_ff;
   logic [dcer_pkg::TIME_W-1:0]       out_time_ff;
   logic [dcer_pkg::SLOT_W-1:0]       slot_ff;
   logic                              last_ff;

   logic [dcer_pkg::LINE_COUNT-1:0]   sel;
   logic [dcer_pkg::LINE_COUNT-1:0]   rest;
   logic [dcer_pkg::LINE_NUM_W-1:0]   pick_line;
   logic [dcer_pkg::SLOT_W-1:0]       pick_slot;
   logic                              pick_level;
   logic                              advance;

   always_comb begin
      // Isolate the lowest pending line, then AND-OR select its fields.
      sel        = mask_ff & (~mask_ff + dcer_pkg::LINE_COUNT'(1));
      rest       = mask_ff & ~sel;
      pick_line  = '0;
      pick_slot  = '0;
      pick_level = 1'b0;
      for (int i = 0; i < dcer_pkg::LINE_COUNT; i++) begin
         pick_line  = pick_line  | ({dcer_pkg::LINE_NUM_W{sel[i]}}
                                    & dcer_pkg::LINE_NUM_W'(i));
         pick_slot  = pick_slot  | ({dcer_pkg::SLOT_W{sel[i]}} & slot_vec[i]);
         pick_level = pick_level | (sel[i] & levels_ff[i]);
      end
      advance = (mask_ff != '0) && (!valid_ff || rsp_ready);

      if (load) begin
         mask_in = fire_vec;
      end else if (advance) begin
         mask_in = rest;
      end else begin
         mask_in = mask_ff;
      end

      if (advance) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         mask_ff  <= mask_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         levels_ff <= level_vec;
         time_ff   <= time_in;
      end
      if (advance) begin
         line_ff     <= pick_line;
         level_ff    <= pick_level;
         out_time_ff <= time_ff;
         slot_ff     <= pick_slot;
         last_ff     <= (rest == '0);
      end
   end

   assign idle            = (mask_ff == '0);
   assign rsp_valid       = valid_ff;
   assign rsp_line_number = line_ff;
   assign rsp_line_level  = level_ff;
   assign rsp_event_time  = $signed(out_time_ff);
   assign rsp_event_slot  = slot_ff;
   assign rsp_last_event  = last_ff;

endmodule

### tb/digital_change_event_recorder_core_tb.sv
// Self-checking testbench for digital_change_event_recorder_core: queues sample items,
// predicts the change events of every accepted item and checks each event in order.
// Depends on dcer_pkg and the RTL in rtl/.
module digital_change_event_recorder_core_tb;
   import dcer_pkg::*;

   // Hang limit: about six times the worst correct run, which has 64 events per item, each
   // behind the longest receive stall.
   localparam int CYCLE_LIMIT   = 1000000;
   // Margin after the last expected event, for items that cause no event.
   localparam int SETTLE_CYCLES = 8;

   localparam logic [TICK_W-1:0]   TICK_MAX   = {TICK_W{1'b1}};
   localparam logic [OFFSET_W-1:0] OFFSET_MAX = {1'b0, {(OFFSET_W-1){1'b1}}};
   localparam logic [OFFSET_W-1:0] OFFSET_MIN = {1'b1, {(OFFSET_W-1){1'b0}}};

   typedef struct packed {
      logic [WORD_W-1:0] word;
      logic [TICK_W-1:0] tick;
      logic              seg_start;
      logic              seg_end;
   } sample_item_type;

   typedef struct packed {
      logic [LINE_NUM_W-1:0] line;
      logic                  level;
      logic [TIME_W-1:0]     ev_time;
      logic [SLOT_W-1:0]     slot;
      logic                  last;
   } line_event_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [WORD_W-1:0]     req_sample_word = '0;
   logic [TICK_W-1:0]     req_tick_stamp = '0;
   logic                  req_segment_start = 1'b0;
   logic                  req_segment_end = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [LINE_NUM_W-1:0] rsp_line_number;
   logic                  rsp_line_level;
   logic signed [TIME_W-1:0] rsp_event_time;
   logic [SLOT_W-1:0]     rsp_event_slot;
   logic                  rsp_last_event;

   digital_change_event_recorder_core dut (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_sample_word   (req_sample_word),
      .req_tick_stamp    (req_tick_stamp),
      .req_segment_start (req_segment_start),
      .req_segment_end   (req_segment_end),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_line_number   (rsp_line_number),
      .rsp_line_level    (rsp_line_level),
      .rsp_event_time    (rsp_event_time),
      .rsp_event_slot    (rsp_event_slot),
      .rsp_last_event    (rsp_last_event)
   );

   // Items waiting for the driver, and events predicted but not yet seen.
   sample_item_type pending_samples[$];
   line_event_type  expected_events[$];
   sample_item_type in_flight;

   int  submitted_count = 0;
   int  accepted_count  = 0;
   int  error_count     = 0;
   int  send_gap        = 0;
   int  recv_stall      = 0;
   bit  idling_on       = 1'b1;

   // Model copy of the registers and of the block state.
   logic [CHAN_W-1:0]   chan_setting   = CHANNELS_RESET;
   logic [OFFSET_W-1:0] offset_setting = '0;
   logic [WORD_W-1:0]   prev_word_model = '0;
   logic [15:0]         line_counts [LINE_COUNT];

   // Random generator state: last word and tick handed out, segment framing.
   logic [WORD_W-1:0] gen_word = '0;
   logic [TICK_W-1:0] gen_tick = '0;
   bit                seg_open = 1'b0;
   int                seg_left = 0;

   initial begin
      foreach (line_counts[i]) line_counts[i] = '0;
   end

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic report_error(input string msg);
      $display("ERROR at cycle edge %0t: %s", $realtime, msg);
      error_count++;
   endtask

   // Work out the events one accepted sample item causes and queue them in line order.
   task automatic predict_events(input sample_item_type s);
      logic [TIME_W-1:0]     ev_time;
      logic [LINE_COUNT-1:0] emit;
      line_event_type        ev;
      int                    lines;
      int                    last_line;
      int                    i;
      ev_time = {2'b00, s.tick} + {offset_setting[OFFSET_W-1], offset_setting};
      // Segment start wipes every count before the word is looked at.
      if (s.seg_start) begin
         for (i = 0; i < LINE_COUNT; i++) line_counts[i] = '0;
      end
      // Channel counts above the line count clamp to all lines.
      lines = (chan_setting > LINE_COUNT) ? LINE_COUNT : int'(chan_setting);
      emit = '0;
      last_line = -1;
      for (i = 0; i < lines; i++) begin
         if (s.seg_start || s.seg_end || (s.word[i] != prev_word_model[i])) begin
            // Drop the event once the line's record is full; the count holds.
            if (line_counts[i] < SEGMENT_MAX) begin
               emit[i] = 1'b1;
               last_line = i;
            end
         end
      end
      for (i = 0; i < lines; i++) begin
         if (emit[i]) begin
            ev.line    = i[LINE_NUM_W-1:0];
            ev.level   = s.word[i];
            ev.ev_time = ev_time;
            ev.slot    = line_counts[i][SLOT_W-1:0];
            ev.last    = (i == last_line);
            expected_events.push_back(ev);
            line_counts[i] = line_counts[i] + 16'd1;
         end
      end
      prev_word_model = s.word;
   endtask

   // Compare one accepted event against the oldest prediction, field by field.
   task automatic check_event();
      line_event_type want;
      if (expected_events.size() == 0) begin
         report_error($sformatf("event on line %0d with nothing expected", rsp_line_number));
      end else begin
         want = expected_events.pop_front();
         if (rsp_line_number !== want.line)
            report_error($sformatf("line_number got %0d expected %0d",
                                   rsp_line_number, want.line));
         if (rsp_line_level !== want.level)
            report_error($sformatf("line %0d line_level got %b expected %b",
                                   want.line, rsp_line_level, want.level));
         if (rsp_event_time !== want.ev_time)
            report_error($sformatf("line %0d event_time got %0d expected %0d", want.line,
                                   rsp_event_time, $signed(want.ev_time)));
         if (rsp_event_slot !== want.slot)
            report_error($sformatf("line %0d event_slot got %0d expected %0d",
                                   want.line, rsp_event_slot, want.slot));
         if (rsp_last_event !== want.last)
            report_error($sformatf("line %0d last_event got %b expected %b",
                                   want.line, rsp_last_event, want.last));
      end
   endtask

   // Driver: launch the next pending item whenever the channel is free, with random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else if (!req_valid || req_ready) begin
         // The item on the wires is taken at this edge: predict it first.
         if (req_valid) begin
            predict_events(in_flight);
            accepted_count++;
         end
         if (send_gap > 0) begin
            send_gap  <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_samples.size() == 0) begin
            req_valid <= 1'b0;
         end else if (idling_on && $urandom_range(0, 5) == 0) begin
            // Idle now and load a random gap into send_gap.
            send_gap  <= $urandom_range(0, 7);
            req_valid <= 1'b0;
         end else begin
            in_flight = pending_samples.pop_front();
            req_valid         <= 1'b1;
            req_sample_word   <= in_flight.word;
            req_tick_stamp    <= in_flight.tick;
            req_segment_start <= in_flight.seg_start;
            req_segment_end   <= in_flight.seg_end;
         end
      end
   end

   // Monitor: check every accepted event and stall the event channel in random bursts.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         recv_stall <= 0;
      end else begin
         if (rsp_valid && rsp_ready) check_event();
         if (recv_stall > 0) begin
            recv_stall <= recv_stall - 1;
            rsp_ready  <= 1'b0;
         end else if (idling_on && $urandom_range(0, 4) == 0) begin
            recv_stall <= $urandom_range(0, 7);
            rsp_ready  <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Hang guard.
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("timeout: %0d items queued, %0d taken, %0d events outstanding",
               submitted_count, accepted_count, expected_events.size());
      $display("== FAIL ==");
      $finish;
   end

   task automatic send(input logic [WORD_W-1:0] word, input logic [TICK_W-1:0] tick,
                       input logic seg_start, input logic seg_end);
      sample_item_type s;
      s.word      = word;
      s.tick      = tick;
      s.seg_start = seg_start;
      s.seg_end   = seg_end;
      pending_samples.push_back(s);
      submitted_count++;
   endtask

   // Write one register and track it in the model; call only while the block idles.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      if (idx == CSR_CHANNELS_IN_USE) chan_setting = data[CHAN_W-1:0];
      else if (idx == CSR_TRIGGER_OFFSET) offset_setting = data[OFFSET_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Hold until every queued item is taken and every predicted event has come,
   // then let the block finish any item that causes no event.
   task automatic wait_idle();
      while (accepted_count != submitted_count || expected_events.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_config(input logic [CHAN_W-1:0] chans,
                             input logic [OFFSET_W-1:0] offset);
      write_csr(CSR_CHANNELS_IN_USE, {{(CSR_DATA_W-CHAN_W){1'b0}}, chans});
      write_csr(CSR_TRIGGER_OFFSET, offset);
   endtask

   // Random items: mostly well-formed segments (start, a few middle samples, end)
   // with level changes from a few bit flips to whole new words, plus noise items with random marks.
   task automatic add_random_items(input int count);
      logic [WORD_W-1:0] w;
      logic              st;
      logic              en;
      int                k;
      int                kind;
      int                b;
      for (k = 0; k < count; k++) begin
         kind = $urandom_range(0, 99);
         w = gen_word;
         if (kind < 15) begin
            // hold the word: only marks can cause events
         end else if (kind < 60) begin
            repeat ($urandom_range(1, 3)) begin
               b = $urandom_range(0, WORD_W - 1);
               w[b] = ~w[b];
            end
         end else if (kind < 90) begin
            w = {$urandom, $urandom};
         end else begin
            w = {WORD_W{kind[0]}};
         end
         if ($urandom_range(0, 19) == 0) gen_tick = TICK_W'({$urandom, $urandom});
         else gen_tick = gen_tick + $urandom_range(1, 1000);
         if ($urandom_range(0, 6) == 0) begin
            st = 1'($urandom_range(0, 1));
            en = 1'($urandom_range(0, 1));
         end else if (!seg_open) begin
            st = 1'b1;
            en = 1'b0;
            seg_open = 1'b1;
            seg_left = $urandom_range(1, 12);
         end else if (seg_left == 0) begin
            st = 1'b0;
            en = 1'b1;
            seg_open = 1'b0;
         end else begin
            st = 1'b0;
            en = 1'b0;
            seg_left--;
         end
         send(w, gen_tick, st, en);
         gen_word = w;
      end
   endtask

   initial begin
      logic [WORD_W-1:0] w;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part, first on the reset register values (all lines, zero offset).
      // Before any segment start the zero counts and zero previous word are used as is.
      send('0, '0, 1'b0, 1'b0);
      send({WORD_W{1'b1}}, TICK_MAX, 1'b0, 1'b0);
      send({WORD_W{1'b1}}, 62'd5, 1'b0, 1'b0);
      w = {$urandom, $urandom};
      send(w, 62'd10, 1'b1, 1'b0);
      w[0] = ~w[0];
      w[WORD_W-1] = ~w[WORD_W-1];
      send(w, 62'd11, 1'b0, 1'b0);
      send(w, 62'd12, 1'b0, 1'b1);
      // Start and end on the same sample: one event per line.
      send({(WORD_W/2){2'b01}}, 62'd20, 1'b1, 1'b1);
      send({(WORD_W/2){2'b10}}, 62'd21, 1'b0, 1'b0);
      wait_idle();

      // Largest positive offset on the largest tick; channel count just above the top.
      set_config(7'd65, OFFSET_MAX);
      send('0, TICK_MAX, 1'b1, 1'b0);
      send({WORD_W{1'b1}}, TICK_MAX, 1'b0, 1'b1);
      wait_idle();

      // No line in use: nothing comes out, but the previous word still moves.
      set_config(7'd0, OFFSET_MIN);
      send({$urandom, $urandom}, '0, 1'b1, 1'b1);
      send({WORD_W{1'b0}}, '0, 1'b0, 1'b0);
      wait_idle();

      // One line only; changes on higher lines are ignored.
      set_config(7'd1, OFFSET_MIN);
      send({{(WORD_W-1){1'b0}}, 1'b1}, '0, 1'b1, 1'b0);
      send('0, 62'd1, 1'b0, 1'b0);
      send({WORD_W{1'b1}} << 1, 62'd2, 1'b0, 1'b0);
      send('0, 62'd3, 1'b0, 1'b1);
      wait_idle();

      // Largest channel value clamps to all lines.
      set_config(7'd127, '0);
      send({WORD_W{1'b1}}, 62'd100, 1'b1, 1'b0);
      send('0, 62'd101, 1'b0, 1'b0);
      wait_idle();

      // Random phases over several settings. Hold the sender midway through the first
      // one until every expected event is back.
      gen_word = prev_word_model;
      set_config(CHANNELS_RESET, OFFSET_W'({$urandom, $urandom}));
      add_random_items(30);
      wait_idle();
      add_random_items(30);
      wait_idle();

      set_config(7'd1, OFFSET_MAX);
      add_random_items(40);
      wait_idle();

      set_config(7'd0, OFFSET_W'({$urandom, $urandom}));
      add_random_items(10);
      wait_idle();

      set_config(CHAN_W'($urandom_range(1, LINE_COUNT)), OFFSET_MIN);
      add_random_items(60);
      wait_idle();

      set_config(7'd127, OFFSET_W'({$urandom, $urandom}));
      add_random_items(50);
      wait_idle();

      // Last stretch runs flat out on both sides.
      idling_on = 1'b0;
      set_config(CHAN_W'($urandom_range(1, LINE_COUNT)), '0);
      add_random_items(40);
      wait_idle();

      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
